@@ rtl/cdl_pkg.sv @@
// shared types, constants and helpers for the cyclic dominance lattice block
// no dependencies; the other rtl files but cdl_ifs and cdl_chk take names from here by scope
package cdl_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int RATE_W       = 16;
  localparam int COUNT_W      = 13;
  localparam int STEP_W       = 32;
  localparam int COUNT_MAX    = 8191;

  typedef logic [1:0] cdl_sp_t;

  localparam cdl_sp_t SP_A    = 2'd0;
  localparam cdl_sp_t SP_B    = 2'd1;
  localparam cdl_sp_t SP_C    = 2'd2;
  // also marks a site that has not been loaded since reset
  localparam cdl_sp_t SP_NONE = 2'd3;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_STEP    = 1'b1;
  localparam logic EV_SWAP      = 1'b0;
  localparam logic EV_PREDATION = 1'b1;

  localparam logic [2:0] DIR_POS_X = 3'd0;
  localparam logic [2:0] DIR_NEG_X = 3'd1;
  localparam logic [2:0] DIR_POS_Y = 3'd2;
  localparam logic [2:0] DIR_NEG_Y = 3'd3;
  localparam logic [2:0] DIR_POS_Z = 3'd4;
  localparam logic [2:0] DIR_NEG_Z = 3'd5;

  typedef enum logic [1:0] {
    REG_SWAP_RATE = 2'd0,
    REG_DEATH_A   = 2'd1,
    REG_DEATH_B   = 2'd2,
    REG_DEATH_C   = 2'd3
  } cdl_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_N,
    ST_EVAL,
    ST_WRITE_N,
    ST_LOAD,
    ST_RESULT,
    ST_CLEAR
  } cdl_state_t;

  // count update from the sequencer to the tally
  typedef struct packed {
    logic    step_en;
    logic    inc_en;
    cdl_sp_t inc_sp;
    logic    dec_en;
    cdl_sp_t dec_sp;
  } cdl_upd_t;

  typedef struct packed {
    logic [RATE_W-1:0]      swap_rate;
    logic [2:0][RATE_W-1:0] death_rate;
  } cdl_rates_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic [COUNT_W-1:0] count_c;
    logic [STEP_W-1:0]  step_count;
    logic               fills;
  } cdl_res_t;

  // code 3 folds onto a
  function automatic cdl_sp_t sp_mod3(input cdl_sp_t v);
    return (v == SP_NONE) ? SP_A : v;
  endfunction

  // the species that v eats
  function automatic cdl_sp_t sp_next(input cdl_sp_t v);
    return (v == SP_C) ? SP_A : cdl_sp_t'(v + 2'd1);
  endfunction

endpackage

@@ rtl/cdl_ifs.sv @@
// valid/ready channel interfaces for lattice commands and result items
// depends on nothing; field widths follow the block's item format
interface cdl_cmd_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  site_x;
  logic [3:0]  site_y;
  logic [3:0]  site_z;
  logic [1:0]  species;
  logic [2:0]  direction;
  logic        event_req;
  logic [15:0] rand_swap;
  logic [15:0] rand_death;

  modport source(output valid, kind, site_x, site_y, site_z, species, direction,
                 event_req, rand_swap, rand_death, input ready);
  modport sink(input valid, kind, site_x, site_y, site_z, species, direction,
               event_req, rand_swap, rand_death, output ready);
endinterface

interface cdl_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] count_a;
  logic [12:0] count_b;
  logic [12:0] count_c;
  logic [31:0] step_count;
  logic        one_species_fills;

  modport source(output valid, count_a, count_b, count_c, step_count, one_species_fills,
                 input ready);
  modport sink(input valid, count_a, count_b, count_c, step_count, one_species_fills,
               output ready);
endinterface

@@ rtl/cyclic_dominance_lattice_step.sv @@
// channel    dir  handshake      payload
// cmd        in   valid/ready    kind, site_x/y/z, species, direction, event_req, rand_*
// rsp        out  valid/ready    count_a/b/c, step_count, one_species_fills
// cfg        in   cfg_we only    cfg_idx selects swap_rate, death_rate_a/b/c
//
// a load item passes through the load and result states before the next accept, a step
// through read_n, eval and result, and a step that rewrites the neighbour site also
// through write_n; the single write port of the site memory and its registered read set
// this. the result register lets the next item be accepted while a result waits. reset
// clears counts and step counter and sets every rate to all ones, then a clearing pass
// marks every site empty with cmd.ready low; an empty site takes part in no swap or predation.
// depends on cdl_pkg, cdl_ifs, cdl_mem, cdl_tally, cdl_seq
module cyclic_dominance_lattice_step #(
  parameter int SIDE = cdl_pkg::SIDE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  cdl_cmd_if.sink     cmd,
  cdl_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(SIDE * SIDE * SIDE);

  cdl_pkg::cdl_rates_t rates;
  cdl_pkg::cdl_upd_t   upd;
  cdl_pkg::cdl_res_t   res;
  logic [2:0]          cnt_nz;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  cdl_pkg::cdl_sp_t    mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      rates.swap_rate  <= '1;
      rates.death_rate <= '1;
    end else if (cfg_we) begin
      unique case (cdl_pkg::cdl_reg_t'(cfg_idx))
        cdl_pkg::REG_SWAP_RATE: rates.swap_rate                     <= cfg_wdata;
        cdl_pkg::REG_DEATH_A:   rates.death_rate[cdl_pkg::SP_A] <= cfg_wdata;
        cdl_pkg::REG_DEATH_B:   rates.death_rate[cdl_pkg::SP_B] <= cfg_wdata;
        cdl_pkg::REG_DEATH_C:   rates.death_rate[cdl_pkg::SP_C] <= cfg_wdata;
        default:                rates.swap_rate                     <= rates.swap_rate;
      endcase
    end
  end

  cdl_seq #(.SIDE(SIDE)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .rates     (rates),
    .cnt_nz    (cnt_nz),
    .res       (res),
    .upd       (upd),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cdl_tally #(.SIDE(SIDE)) u_tally (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .cnt_nz (cnt_nz),
    .res    (res)
  );

  cdl_mem #(.SIDE(SIDE)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/cdl_mem.sv @@
// lattice site memory: one write port, one read port with registered read data
// depends on cdl_pkg for the species code type
module cdl_mem #(
  parameter int  SIDE  = cdl_pkg::SIDE_DEFAULT,
  localparam int DEPTH = SIDE * SIDE * SIDE,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cdl_pkg::cdl_sp_t wdata,
  input  logic [AW-1:0]   raddr,
  output cdl_pkg::cdl_sp_t rdata
);

  cdl_pkg::cdl_sp_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cdl_tally.sv @@
// species counts, saturating step counter and the result fields built from them
// depends on cdl_pkg for the update and result structs
module cdl_tally #(
  parameter int  SIDE  = cdl_pkg::SIDE_DEFAULT,
  localparam int SITES = SIDE * SIDE * SIDE,
  localparam int CNT_W = $clog2(SITES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  cdl_pkg::cdl_upd_t upd,
  output logic [2:0]        cnt_nz,
  output cdl_pkg::cdl_res_t res
);

  localparam int EW = (CNT_W > cdl_pkg::COUNT_W) ? CNT_W : cdl_pkg::COUNT_W;

  logic [2:0][CNT_W-1:0]        cnt;
  logic [cdl_pkg::STEP_W-1:0]   step;

  function automatic logic [cdl_pkg::COUNT_W-1:0] clamp(input logic [CNT_W-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return (e > EW'(cdl_pkg::COUNT_MAX)) ? cdl_pkg::COUNT_W'(cdl_pkg::COUNT_MAX)
                                          : e[cdl_pkg::COUNT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      step <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        cnt[i] <= cnt[i] + CNT_W'(upd.inc_en && upd.inc_sp == 2'(i))
                         - CNT_W'(upd.dec_en && upd.dec_sp == 2'(i));
      end
      if (upd.step_en && step != '1) begin
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnt_nz[i] = (cnt[i] != '0);
    end
    res.count_a    = clamp(cnt[cdl_pkg::SP_A]);
    res.count_b    = clamp(cnt[cdl_pkg::SP_B]);
    res.count_c    = clamp(cnt[cdl_pkg::SP_C]);
    res.step_count = step;
    res.fills      = (cnt[cdl_pkg::SP_A] == CNT_W'(SITES))
                  || (cnt[cdl_pkg::SP_B] == CNT_W'(SITES))
                  || (cnt[cdl_pkg::SP_C] == CNT_W'(SITES));
  end

endmodule

@@ rtl/cdl_seq.sv @@
// item sequencer: address generation, read-modify-write of the site memory,
// interaction decisions and the result register; depends on cdl_pkg, cdl_ifs
module cdl_seq #(
  parameter int  SIDE = cdl_pkg::SIDE_DEFAULT,
  localparam int CW   = $clog2(SIDE),
  localparam int AW   = $clog2(SIDE * SIDE * SIDE)
) (
  input  logic                clk,
  input  logic                rst,
  cdl_cmd_if.sink             cmd,
  cdl_rsp_if.source           rsp,
  input  cdl_pkg::cdl_rates_t rates,
  input  logic [2:0]          cnt_nz,
  input  cdl_pkg::cdl_res_t   res,
  output cdl_pkg::cdl_upd_t   upd,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output cdl_pkg::cdl_sp_t    mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  cdl_pkg::cdl_sp_t    mem_rdata
);

  cdl_pkg::cdl_state_t state, state_next;

  logic [CW-1:0]              x_q, y_q, z_q;
  logic [CW-1:0]              nx, ny, nz;
  cdl_pkg::cdl_sp_t           sp_q, me_q;
  logic [2:0]                 dir_q;
  logic                       ev_q;
  logic [cdl_pkg::RATE_W-1:0] rs_q, rd_q;
  logic [AW-1:0]              s_addr, cmd_addr, n_addr;
  logic [AW-1:0]              clr_addr;
  logic                       dir_ok;
  logic                       site_ok_q, pair_ok;
  cdl_pkg::cdl_sp_t           other, prey, pred;
  logic                       swap_ok, eat_ok, eaten_ok;
  logic                       rsp_valid, rsp_load;
  cdl_pkg::cdl_res_t          rsp_data;

  // coordinate modulo SIDE through a 16-entry constant table
  function automatic logic [CW-1:0] wrap(input logic [3:0] c);
    logic [CW-1:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (c == 4'(k)) begin
        r = CW'(k % SIDE);
      end
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] a, b, c);
    return AW'((AW'(a) * AW'(SIDE) + AW'(b)) * AW'(SIDE) + AW'(c));
  endfunction

  function automatic logic [CW-1:0] up(input logic [CW-1:0] c);
    return (c == CW'(SIDE - 1)) ? '0 : CW'(c + CW'(1));
  endfunction

  function automatic logic [CW-1:0] down(input logic [CW-1:0] c);
    return (c == '0) ? CW'(SIDE - 1) : CW'(c - CW'(1));
  endfunction

  assign cmd_addr = addr_of(wrap(cmd.site_x), wrap(cmd.site_y), wrap(cmd.site_z));

  always_comb begin
    nx     = x_q;
    ny     = y_q;
    nz     = z_q;
    dir_ok = 1'b1;
    unique case (dir_q)
      cdl_pkg::DIR_POS_X: nx = up(x_q);
      cdl_pkg::DIR_NEG_X: nx = down(x_q);
      cdl_pkg::DIR_POS_Y: ny = up(y_q);
      cdl_pkg::DIR_NEG_Y: ny = down(y_q);
      cdl_pkg::DIR_POS_Z: nz = up(z_q);
      cdl_pkg::DIR_NEG_Z: nz = down(z_q);
      default:            dir_ok = 1'b0;
    endcase
  end

  assign n_addr = addr_of(nx, ny, nz);

  // neighbour data arrives from memory in the eval cycle
  always_comb begin
    // an empty site on either side blocks any interaction
    pair_ok  = site_ok_q && mem_rdata != cdl_pkg::SP_NONE;
    other    = cdl_pkg::sp_mod3(mem_rdata);
    prey     = cdl_pkg::sp_next(me_q);
    pred     = cdl_pkg::sp_next(prey);
    swap_ok  = dir_ok && pair_ok && ev_q == cdl_pkg::EV_SWAP && other != me_q
            && rs_q <= rates.swap_rate;
    eat_ok   = dir_ok && pair_ok && ev_q == cdl_pkg::EV_PREDATION && other == prey
            && cnt_nz[prey] && rd_q <= rates.death_rate[prey];
    eaten_ok = dir_ok && pair_ok && ev_q == cdl_pkg::EV_PREDATION && other == pred
            && cnt_nz[me_q] && rd_q <= rates.death_rate[me_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // walks every site once after reset to mark it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == cdl_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = s_addr;
    mem_wdata  = me_q;
    mem_raddr  = n_addr;
    upd        = '0;
    rsp_load   = 1'b0;
    unique case (state)
      cdl_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = cdl_pkg::SP_NONE;
        if (clr_addr == AW'(SIDE * SIDE * SIDE - 1)) begin
          state_next = cdl_pkg::ST_IDLE;
        end
      end
      cdl_pkg::ST_IDLE: begin
        mem_raddr = cmd_addr;
        if (cmd.valid) begin
          state_next = (cmd.kind == cdl_pkg::KIND_LOAD) ? cdl_pkg::ST_LOAD
                                                        : cdl_pkg::ST_READ_N;
        end
      end
      cdl_pkg::ST_READ_N: begin
        state_next = cdl_pkg::ST_EVAL;
      end
      cdl_pkg::ST_EVAL: begin
        upd.step_en = 1'b1;
        state_next  = cdl_pkg::ST_RESULT;
        if (swap_ok) begin
          mem_we     = 1'b1;
          mem_wdata  = other;
          state_next = cdl_pkg::ST_WRITE_N;
        end else if (eat_ok) begin
          upd.dec_en = 1'b1;
          upd.dec_sp = prey;
          upd.inc_en = 1'b1;
          upd.inc_sp = me_q;
          state_next = cdl_pkg::ST_WRITE_N;
        end else if (eaten_ok) begin
          mem_we     = 1'b1;
          mem_wdata  = pred;
          upd.dec_en = 1'b1;
          upd.dec_sp = me_q;
          upd.inc_en = 1'b1;
          upd.inc_sp = pred;
        end
      end
      cdl_pkg::ST_WRITE_N: begin
        // the neighbour always takes the site's own species
        mem_we     = 1'b1;
        mem_waddr  = n_addr;
        state_next = cdl_pkg::ST_RESULT;
      end
      cdl_pkg::ST_LOAD: begin
        if (sp_q != cdl_pkg::SP_NONE) begin
          mem_we     = 1'b1;
          mem_wdata  = sp_q;
          upd.dec_en = (mem_rdata != cdl_pkg::SP_NONE)
                    && cnt_nz[cdl_pkg::sp_mod3(mem_rdata)];
          upd.dec_sp = cdl_pkg::sp_mod3(mem_rdata);
          upd.inc_en = 1'b1;
          upd.inc_sp = sp_q;
        end
        state_next = cdl_pkg::ST_RESULT;
      end
      cdl_pkg::ST_RESULT: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = cdl_pkg::ST_IDLE;
        end
      end
      default: state_next = cdl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == cdl_pkg::ST_IDLE && cmd.valid) begin
      x_q    <= wrap(cmd.site_x);
      y_q    <= wrap(cmd.site_y);
      z_q    <= wrap(cmd.site_z);
      s_addr <= cmd_addr;
      sp_q   <= cmd.species;
      dir_q  <= cmd.direction;
      ev_q   <= cmd.event_req;
      rs_q   <= cmd.rand_swap;
      rd_q   <= cmd.rand_death;
    end
    if (state == cdl_pkg::ST_READ_N) begin
      me_q      <= cdl_pkg::sp_mod3(mem_rdata);
      site_ok_q <= (mem_rdata != cdl_pkg::SP_NONE);
    end
    if (rsp_load) begin
      rsp_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign cmd.ready             = (state == cdl_pkg::ST_IDLE);
  assign rsp.valid             = rsp_valid;
  assign rsp.count_a           = rsp_data.count_a;
  assign rsp.count_b           = rsp_data.count_b;
  assign rsp.count_c           = rsp_data.count_c;
  assign rsp.step_count        = rsp_data.step_count;
  assign rsp.one_species_fills = rsp_data.fills;

endmodule

@@ rtl/cdl_chk.sv @@
// port-level checker for the lattice block, bound to the top level
// depends on cyclic_dominance_lattice_step and its channel interfaces
module cdl_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [12:0] count_a,
  input logic [12:0] count_b,
  input logic [12:0] count_c,
  input logic [31:0] step_count,
  input logic        fills
);

  // out of reset: clearing the site memory, no result pending
  a_reset_state: assert property (@(posedge clk) rst |=> !cmd_ready && !rsp_valid)
    else $error("block not clearing after reset");

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("item accepted while another is in work");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(count_a) && $stable(count_b)
      && $stable(count_c) && $stable(step_count) && $stable(fills))
    else $error("stalled result item changed");

endmodule

bind cyclic_dominance_lattice_step cdl_chk u_cdl_chk (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .count_a    (rsp.count_a),
  .count_b    (rsp.count_b),
  .count_c    (rsp.count_c),
  .step_count (rsp.step_count),
  .fills      (rsp.one_species_fills)
);

@@ bench/lattice_tb_pkg.sv @@
// shared helpers for the lattice bench: lattice size, the two no-move direction
// codes and the periodic neighbour lookup; depends on cdl_pkg
package lattice_tb_pkg;
  import cdl_pkg::*;

  localparam int SITE_COUNT = SIDE_DEFAULT * SIDE_DEFAULT * SIDE_DEFAULT;

  // direction codes past -z name no neighbour
  localparam logic [2:0] DIR_STAY_A = 3'd6;
  localparam logic [2:0] DIR_STAY_B = 3'd7;

  // site index is {x, y, z}; 4-bit fields wrap on their own
  function automatic logic [11:0] neighbour_site(input logic [11:0] site,
                                                 input logic [2:0] dir);
    logic [3:0] x, y, z;
    {x, y, z} = site;
    case (dir)
      DIR_POS_X: x = x + 4'd1;
      DIR_NEG_X: x = x - 4'd1;
      DIR_POS_Y: y = y + 4'd1;
      DIR_NEG_Y: y = y - 4'd1;
      DIR_POS_Z: z = z + 4'd1;
      DIR_NEG_Z: z = z - 4'd1;
      default: ;
    endcase
    return {x, y, z};
  endfunction

endpackage

@@ bench/lattice_step_checker.sv @@
// watches the command, result and rate-write ports of the lattice block, keeps its
// own lattice, tallies and rates, and compares every result item in order
// depends on cdl_pkg, lattice_tb_pkg, cdl_cmd_if and cdl_rsp_if
module lattice_step_checker
  import cdl_pkg::*;
  import lattice_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cdl_cmd_if          cmd,
  cdl_rsp_if          rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] swap_thr;
  logic [15:0] death_thr [3];
  cdl_sp_t     lattice [SITE_COUNT];
  bit          occupied [SITE_COUNT];
  int unsigned held [3];
  logic [31:0] steps_taken;
  cdl_res_t    tally_q [$];

  function automatic cdl_sp_t prey_of(input cdl_sp_t v);
    case (v)
      SP_A: return SP_B;
      SP_B: return SP_C;
      default: return SP_A;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(input int unsigned v);
    return (v > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(v);
  endfunction

  function automatic void interact(input logic [11:0] s, input logic [2:0] dir,
                                   input logic ev, input logic [15:0] rs,
                                   input logic [15:0] rd);
    logic [11:0] n;
    cdl_sp_t me, other, prey, pred;
    if (dir > DIR_NEG_Z) return;
    n = neighbour_site(s, dir);
    if (!occupied[s] || !occupied[n]) return;
    me = lattice[s];
    other = lattice[n];
    prey = prey_of(me);
    pred = prey_of(prey);
    if (other == me) return;
    if (ev == EV_SWAP) begin
      if (rs <= swap_thr) begin
        lattice[s] = other;
        lattice[n] = me;
      end
    end else if (other == prey) begin
      // site owner eats the neighbour
      if (held[prey] > 0 && rd <= death_thr[prey]) begin
        lattice[n] = me;
        held[prey]--;
        held[me]++;
      end
    end else if (held[me] > 0 && rd <= death_thr[me]) begin
      // neighbour eats the site owner
      lattice[s] = pred;
      held[me]--;
      held[pred]++;
    end
  endfunction

  function automatic cdl_res_t advance_lattice();
    logic [11:0] s;
    cdl_res_t r;
    s = {cmd.site_x, cmd.site_y, cmd.site_z};
    if (cmd.kind == KIND_LOAD) begin
      if (cmd.species != SP_NONE) begin
        if (occupied[s] && held[lattice[s]] > 0) held[lattice[s]]--;
        lattice[s] = cmd.species;
        occupied[s] = 1'b1;
        held[cmd.species]++;
      end
    end else begin
      if (steps_taken != '1) steps_taken++;
      interact(s, cmd.direction, cmd.event_req, cmd.rand_swap, cmd.rand_death);
    end
    r.count_a = count_field(held[SP_A]);
    r.count_b = count_field(held[SP_B]);
    r.count_c = count_field(held[SP_C]);
    r.step_count = steps_taken;
    r.fills = (held[SP_A] == SITE_COUNT) || (held[SP_B] == SITE_COUNT) ||
              (held[SP_C] == SITE_COUNT);
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cdl_res_t want;
    if (rst) begin
      swap_thr = '1;
      for (int i = 0; i < 3; i++) begin
        death_thr[i] = '1;
        held[i] = 0;
      end
      for (int i = 0; i < SITE_COUNT; i++) occupied[i] = 1'b0;
      steps_taken = '0;
      tally_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cdl_reg_t'(cfg_idx))
          REG_SWAP_RATE: swap_thr = cfg_wdata;
          REG_DEATH_A:   death_thr[SP_A] = cfg_wdata;
          REG_DEATH_B:   death_thr[SP_B] = cfg_wdata;
          REG_DEATH_C:   death_thr[SP_C] = cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) tally_q.push_back(advance_lattice());
      if (rsp.valid && rsp.ready) begin
        if (tally_q.size() == 0) begin
          $error("result item with no command item waiting");
          fail_count++;
        end else begin
          want = tally_q.pop_front();
          compare_field("count_a", want.count_a, rsp.count_a);
          compare_field("count_b", want.count_b, rsp.count_b);
          compare_field("count_c", want.count_c, rsp.count_c);
          compare_field("step_count", want.step_count, rsp.step_count);
          compare_field("one_species_fills", want.fills, rsp.one_species_fills);
        end
      end
    end
    pending <= tally_q.size();
  end

endmodule

@@ bench/tb_cyclic_dominance_lattice_step.sv @@
// top of the lattice bench: clock, reset, rate writes and command items, with
// random idling on both channels; lattice_step_checker does the predicting
// depends on cdl_pkg, cdl_ifs, lattice_tb_pkg, lattice_step_checker and the block
module tb_cyclic_dominance_lattice_step;
  import cdl_pkg::*;
  import lattice_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RSP_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS     = 450;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          results_owed;
  bit          no_idle;
  logic        hold_ask = 1'b0;

  logic [15:0] rate_now [4];
  bit          loaded [SITE_COUNT];
  logic [11:0] loaded_list [$];

  cdl_cmd_if cmd_ch ();
  cdl_rsp_if rsp_ch ();

  cyclic_dominance_lattice_step dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lattice_step_checker lattice_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (mismatches),
    .pending    (results_owed)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic send_cmd(input logic kind, input logic [11:0] site, input cdl_sp_t sp,
                          input logic [2:0] dir, input logic ev,
                          input logic [15:0] rs, input logic [15:0] rd);
    if (!no_idle && $urandom_range(99) < 29) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= kind;
    {cmd_ch.site_x, cmd_ch.site_y, cmd_ch.site_z} <= site;
    cmd_ch.species <= sp;
    cmd_ch.direction <= dir;
    cmd_ch.event_req <= ev;
    cmd_ch.rand_swap <= rs;
    cmd_ch.rand_death <= rd;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // unused fields of a load still carry random bits
  task automatic load_site(input logic [11:0] site, input cdl_sp_t sp);
    if (sp != SP_NONE && !loaded[site]) begin
      loaded[site] = 1'b1;
      loaded_list.push_back(site);
    end
    send_cmd(KIND_LOAD, site, sp, 3'($urandom_range(0, 7)), 1'($urandom_range(1)),
             16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
  endtask

  task automatic step_site(input logic [11:0] site, input logic [2:0] dir, input logic ev,
                           input logic [15:0] rs, input logic [15:0] rd);
    send_cmd(KIND_STEP, site, cdl_sp_t'($urandom_range(0, 3)), dir, ev, rs, rd);
  endtask

  // stop offering items and wait until every result item has come back
  task automatic wait_quiet();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input cdl_reg_t r, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    rate_now[r] = v;
    @(posedge clk);
  endtask

  task automatic write_rates(input logic [15:0] sw, input logic [15:0] da,
                             input logic [15:0] db, input logic [15:0] dc);
    wait_quiet();
    write_reg(REG_SWAP_RATE, sw);
    write_reg(REG_DEATH_A, da);
    write_reg(REG_DEATH_B, db);
    write_reg(REG_DEATH_C, dc);
    cfg_we <= 1'b0;
  endtask

  // randoms cluster around the threshold so both sides of the test are hit
  function automatic logic [15:0] pick_fraction(input logic [15:0] thr);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return (thr == 16'd0) ? 16'd1 : thr;
    if (roll < 20) return (thr == 16'hFFFF) ? thr : thr + 16'd1;
    if (roll < 25) return 16'd1;
    if (roll < 30) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  // steps only touch loaded sites; an unloaded neighbour gets loaded instead
  task automatic random_item();
    logic [11:0] s, n;
    logic [2:0] dir;
    int roll;
    roll = $urandom_range(99);
    if (roll < 12 || loaded_list.size() == 0) begin
      load_site(12'($urandom_range(0, SITE_COUNT - 1)),
                (roll < 2) ? SP_NONE : cdl_sp_t'($urandom_range(0, 2)));
    end else begin
      s = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      dir = ($urandom_range(99) < 5) ? 3'($urandom_range(DIR_STAY_A, DIR_STAY_B))
                                     : 3'($urandom_range(DIR_POS_X, DIR_NEG_Z));
      n = (dir <= DIR_NEG_Z) ? neighbour_site(s, dir) : s;
      if (!loaded[n]) begin
        load_site(n, cdl_sp_t'($urandom_range(0, 2)));
      end else begin
        step_site(s, dir, 1'($urandom_range(1)), pick_fraction(rate_now[REG_SWAP_RATE]),
                  pick_fraction(rate_now[$urandom_range(REG_DEATH_A, REG_DEATH_C)]));
      end
    end
  endtask

  task automatic random_phase(input int n_items);
    for (int i = 0; i < n_items; i++) random_item();
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask <= 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_idx <= REG_SWAP_RATE;
    cfg_wdata <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind <= KIND_LOAD;
    cmd_ch.site_x <= '0;
    cmd_ch.site_y <= '0;
    cmd_ch.site_z <= '0;
    cmd_ch.species <= SP_A;
    cmd_ch.direction <= DIR_POS_X;
    cmd_ch.event_req <= EV_SWAP;
    cmd_ch.rand_swap <= 16'd1;
    cmd_ch.rand_death <= 16'd1;
    for (int i = 0; i < 4; i++) rate_now[i] = '1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // corners with wraparound on every axis, rates at reset value
    load_site(12'h000, SP_A);
    load_site(12'hFFF, SP_B);
    load_site(12'h0FF, SP_C);
    load_site(12'h000, SP_NONE);
    load_site(12'h000, SP_B);
    load_site(12'h000, SP_A);
    step_site(12'hFFF, DIR_POS_X, EV_PREDATION, 16'd1, 16'hFFFF);
    load_site(12'h0FF, SP_C);
    step_site(12'h0FF, DIR_NEG_X, EV_PREDATION, 16'd1, 16'hFFFF);
    load_site(12'h0FF, SP_C);
    step_site(12'hFFF, DIR_POS_X, EV_SWAP, 16'hFFFF, 16'd1);
    load_site(12'hFF0, SP_A);
    step_site(12'hFFF, DIR_POS_Z, EV_PREDATION, 16'hFFFF, 16'd1);
    load_site(12'hF0F, SP_A);
    step_site(12'hFFF, DIR_POS_Y, EV_SWAP, 16'd1, 16'hFFFF);
    step_site(12'hF0F, DIR_NEG_Y, EV_SWAP, 16'hFFFF, 16'hFFFF);
    step_site(12'hFF0, DIR_NEG_Z, EV_PREDATION, 16'd1, 16'd1);
    step_site(12'h000, DIR_STAY_A, EV_SWAP, 16'd1, 16'd1);
    step_site(12'h000, DIR_STAY_B, EV_PREDATION, 16'hFFFF, 16'hFFFF);
    load_site(12'h001, SP_A);
    step_site(12'h000, DIR_POS_Z, EV_PREDATION, 16'd1, 16'd1);

    write_rates(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(PHASE_ITEMS);

    write_rates(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    no_idle = 1'b0;

    // results back up behind a long receiver stall
    write_rates(16'd32768, 16'hFFFF, 16'd0, 16'd20000);
    hold_ask <= 1'b1;
    random_phase(PHASE_ITEMS);

    write_rates(16'($urandom), 16'hFFFF, 16'($urandom), 16'd1);
    random_phase(PHASE_ITEMS);

    // one species over the whole lattice, then broken and restored
    write_rates('1, '1, '1, '1);
    for (int i = 0; i < SITE_COUNT; i++) load_site(12'(i), SP_A);
    step_site(12'h123, DIR_POS_X, EV_PREDATION, 16'd1, 16'd1);
    load_site(12'h123, SP_B);
    step_site(12'h123, DIR_POS_X, EV_SWAP, 16'hFFFF, 16'd1);
    step_site(12'h223, DIR_NEG_X, EV_PREDATION, 16'd1, 16'hFFFF);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb_cyclic_dominance_lattice_step: clean");
    end else begin
      $display("tb_cyclic_dominance_lattice_step: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb_cyclic_dominance_lattice_step: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/cdl_pkg.sv
rtl/cdl_ifs.sv
rtl/cdl_mem.sv
rtl/cdl_tally.sv
rtl/cdl_seq.sv
rtl/cyclic_dominance_lattice_step.sv
rtl/cdl_chk.sv
bench/lattice_tb_pkg.sv
bench/lattice_step_checker.sv
bench/tb_cyclic_dominance_lattice_step.sv
